// ===== design/isotp_rr_pkg.sv =====
// Shared types, constants and codes of the ISO-TP receive reassembler.
package isotp_rr_pkg;

   localparam int SLOTS_DEFAULT         = 8;
   localparam int MAX_MSG_BYTES_DEFAULT = 256;

   localparam int KEY_W  = 37;
   localparam int META_W = 6;
   localparam int TS_W   = 64;
   localparam int DECL_W = 12;
   // Fill counts reach at most 4095 at the largest message size.
   localparam int FILL_W = 13;
   localparam int POS_W  = FILL_W - 3;

   localparam int REQ_DATA_W = 168;
   localparam int RSP_DATA_W = 192;

   // Protocol control information frame types.
   localparam logic [3:0] FT_SINGLE      = 4'h0;
   localparam logic [3:0] FT_FIRST       = 4'h1;
   localparam logic [3:0] FT_CONSECUTIVE = 4'h2;

   typedef struct packed {
      logic [KEY_W-1:0]  key;
      logic [META_W-1:0] meta;
      logic [TS_W-1:0]   ts;
      logic [DECL_W-1:0] declared;
      logic [FILL_W-1:0] fill;
   } slot_rec_type;

   typedef struct packed {
      logic hit;
      logic full;
   } slot_flags_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MATCH,
      ST_LOOK,
      ST_DECIDE,
      ST_RD,
      ST_LOAD,
      ST_POST,
      ST_SF,
      ST_FFOPEN
   } state_type;

endpackage

// ===== design/isotp_receive_reassembler.sv =====
// Top level of the ISO-TP receive reassembler: sequencer, slot records, payload lanes.
//
//  channel | dir | handshake             | carries
//  req     | in  | req_tvalid/req_tready | one CAN frame word
//  rsp     | out | rsp_tvalid/rsp_tready | one 8-byte message chunk word, tlast on the final
//  csr     | in  | csr_valid/csr_ready   | extended_addressing
//
// A frame passes the accept, match, record read and decision states; a single or first
// frame then the post and single or first frame states, a completed consecutive frame the
// post state. Each chunk adds a read state and a load state, as RAM reads are registered.
// Reset clears the valid bits and the sequencer; the RAMs need no clearing.
// A stalled rsp channel holds the sequencer in the chunk load or single frame state; req
// is not taken until the frame's chunks have all entered the output register.
module isotp_receive_reassembler #(
   parameter int SLOTS         = isotp_rr_pkg::SLOTS_DEFAULT,
   parameter int MAX_MSG_BYTES = isotp_rr_pkg::MAX_MSG_BYTES_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // frame_id[28:0], frame_data[92:29], bus[96:93], is_extended_id[97],
   // is_received[98], timestamp[162:99], zero pad
   input  logic [isotp_rr_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // msg_id[36:0], out_bus[40:37], out_extended_id[41], out_received[42],
   // out_timestamp[106:43], declared_len[118:107], chunk_index[123:119],
   // chunk_data[187:124], chunk_bytes[191:188]
   output logic [isotp_rr_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // is_partial[0]
   output logic                                rsp_tuser,
   output logic                                rsp_tlast,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic                                csr_wdata
);

   localparam int SW     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int WPS    = (MAX_MSG_BYTES + 7) / 8;
   localparam int PDEPTH = SLOTS * WPS;
   localparam int PAW    = (PDEPTH > 1) ? $clog2(PDEPTH) : 1;
   localparam int REC_W  = $bits(isotp_rr_pkg::slot_rec_type);

   // Accepted frame.
   logic [28:0]                        id_ff;
   logic [63:0]                        data_ff;
   logic [isotp_rr_pkg::META_W-1:0]    meta_ff;
   logic [63:0]                        ts_ff;
   logic                               ext_ff;
   logic                               ext_addr_ff;

   isotp_rr_pkg::state_type            state_ff, state_in;

   // Message being sent out of a slot.
   isotp_rr_pkg::slot_rec_type         em_rec_ff, em_rec_in;
   logic                               em_partial_ff, em_partial_in;
   logic [SW-1:0]                      em_slot_ff, em_slot_in;
   logic [isotp_rr_pkg::POS_W-1:0]     em_pos_ff, em_pos_in;

   // Output register.
   logic                               out_valid_ff;
   logic [isotp_rr_pkg::RSP_DATA_W-1:0] out_data_ff, out_data_in;
   logic                               out_partial_ff, out_partial_in;
   logic                               out_last_ff, out_last_in;
   logic                               out_load;

   // Derived frame fields.
   logic [7:0]                         pci;
   logic [3:0]                         ftype, flen;
   logic [isotp_rr_pkg::KEY_W-1:0]     key;
   logic [63:0]                        src_cf, src_ff;
   logic [isotp_rr_pkg::DECL_W-1:0]    ff_decl;
   logic [3:0]                         cap;
   logic [63:0]                        sf_bytes;

   // Slot search and records.
   isotp_rr_pkg::slot_flags_type       flags;
   logic [SW-1:0]                      hit_idx, free_idx;
   logic                               cmp_en, set_en, clr_en;
   logic [SW-1:0]                      clr_idx;
   logic                               rec_wr_en, rec_rd_en;
   logic [SW-1:0]                      rec_wr_addr;
   isotp_rr_pkg::slot_rec_type         rec_wr_data, rec_rd;
   logic [REC_W-1:0]                   rec_rd_raw;

   // Payload lanes.
   logic                               pl_wr;
   logic [SW-1:0]                      pl_slot;
   logic [isotp_rr_pkg::FILL_W-1:0]    pl_fill;
   logic [3:0]                         pl_n;
   logic [63:0]                        pl_src;
   logic [7:0]                         lane_we;
   logic [PAW-1:0]                     lane_waddr [8];
   logic [7:0]                         lane_wdata [8];
   logic [7:0]                         lane_rdata [8];
   logic [PAW-1:0]                     pl_raddr;
   logic                               pl_rd_en;

   // Consecutive frame arithmetic.
   logic [isotp_rr_pkg::FILL_W-1:0]    cf_rem, cf_ln, cf_newfill;
   // Chunk arithmetic.
   logic [isotp_rr_pkg::FILL_W-1:0]    em_remain;
   logic [3:0]                         em_n;
   logic [63:0]                        em_bytes;

   assign req_tready = (state_ff == isotp_rr_pkg::ST_IDLE);
   assign csr_ready  = 1'b1;

   always_comb begin
      pci     = ext_ff ? data_ff[15:8] : data_ff[7:0];
      ftype   = pci[7:4];
      flen    = pci[3:0];
      key     = ext_ff ? {id_ff, data_ff[7:0]} : {8'd0, id_ff};
      src_cf  = ext_ff ? (data_ff >> 16) : (data_ff >> 8);
      src_ff  = ext_ff ? (data_ff >> 24) : (data_ff >> 16);
      ff_decl = {flen, (ext_ff ? data_ff[23:16] : data_ff[15:8])};
      cap     = ext_ff ? 4'd6 : 4'd7;
   end

   always_comb begin
      for (int l = 0; l < 8; l++) begin
         sf_bytes[8*l +: 8] = ({1'b0, 3'(l)} < flen) ? src_cf[8*l +: 8] : 8'd0;
      end
   end

   assign rec_rd = isotp_rr_pkg::slot_rec_type'(rec_rd_raw);

   always_comb begin
      cf_rem     = ({1'b0, rec_rd.declared} > rec_rd.fill)
                   ? ({1'b0, rec_rd.declared} - rec_rd.fill) : '0;
      cf_ln      = (cf_rem > isotp_rr_pkg::FILL_W'(cap)) ? isotp_rr_pkg::FILL_W'(cap) : cf_rem;
      cf_newfill = rec_rd.fill + cf_ln;
   end

   always_comb begin
      em_remain = em_rec_ff.fill - {em_pos_ff, 3'b000};
      em_n      = (em_remain > isotp_rr_pkg::FILL_W'(8)) ? 4'd8 : em_remain[3:0];
      for (int l = 0; l < 8; l++) begin
         em_bytes[8*l +: 8] = ({1'b0, 3'(l)} < em_n) ? lane_rdata[l] : 8'd0;
      end
   end

   // Each byte lane takes at most one of the up to seven new bytes.
   always_comb begin
      logic [2:0]                      j;
      logic [isotp_rr_pkg::FILL_W-1:0] p;
      for (int l = 0; l < 8; l++) begin
         j             = 3'(l) - pl_fill[2:0];
         p             = pl_fill + isotp_rr_pkg::FILL_W'(j);
         lane_we[l]    = pl_wr && ({1'b0, j} < pl_n);
         lane_waddr[l] = PAW'(pl_slot) * PAW'(WPS) + PAW'(p[isotp_rr_pkg::FILL_W-1:3]);
         lane_wdata[l] = pl_src[8*j +: 8];
      end
   end

   assign pl_raddr = PAW'(em_slot_ff) * PAW'(WPS) + PAW'(em_pos_ff);

   always_comb begin
      state_in       = state_ff;
      em_rec_in      = em_rec_ff;
      em_partial_in  = em_partial_ff;
      em_slot_in     = em_slot_ff;
      em_pos_in      = em_pos_ff;
      out_load       = 1'b0;
      out_data_in    = out_data_ff;
      out_partial_in = out_partial_ff;
      out_last_in    = out_last_ff;
      cmp_en         = 1'b0;
      set_en         = 1'b0;
      clr_en         = 1'b0;
      clr_idx        = hit_idx;
      rec_rd_en      = 1'b0;
      rec_wr_en      = 1'b0;
      rec_wr_addr    = hit_idx;
      rec_wr_data    = rec_rd;
      pl_wr          = 1'b0;
      pl_slot        = hit_idx;
      pl_fill        = rec_rd.fill;
      pl_n           = cf_ln[3:0];
      pl_src         = src_cf;
      pl_rd_en       = 1'b0;

      unique case (state_ff)
         isotp_rr_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               state_in = isotp_rr_pkg::ST_MATCH;
            end
         end
         isotp_rr_pkg::ST_MATCH: begin
            cmp_en   = 1'b1;
            state_in = isotp_rr_pkg::ST_LOOK;
         end
         isotp_rr_pkg::ST_LOOK: begin
            rec_rd_en = 1'b1;
            state_in  = isotp_rr_pkg::ST_DECIDE;
         end
         isotp_rr_pkg::ST_DECIDE: begin
            state_in = isotp_rr_pkg::ST_IDLE;
            case (ftype) inside
               isotp_rr_pkg::FT_SINGLE, isotp_rr_pkg::FT_FIRST: begin
                  if (flags.hit) begin
                     em_rec_in     = rec_rd;
                     em_partial_in = rec_rd.fill < {1'b0, rec_rd.declared};
                     em_slot_in    = hit_idx;
                     em_pos_in     = '0;
                     clr_en        = 1'b1;
                     state_in      = isotp_rr_pkg::ST_RD;
                  end else begin
                     state_in = isotp_rr_pkg::ST_POST;
                  end
               end
               isotp_rr_pkg::FT_CONSECUTIVE: begin
                  if (flags.hit) begin
                     pl_wr            = 1'b1;
                     rec_wr_en        = 1'b1;
                     rec_wr_data.fill = cf_newfill;
                     if (cf_newfill >= {1'b0, rec_rd.declared}) begin
                        em_rec_in      = rec_rd;
                        em_rec_in.fill = cf_newfill;
                        em_partial_in  = 1'b0;
                        em_slot_in     = hit_idx;
                        em_pos_in      = '0;
                        clr_en         = 1'b1;
                        state_in       = isotp_rr_pkg::ST_RD;
                     end
                  end
               end
               default: begin
                  state_in = isotp_rr_pkg::ST_IDLE;
               end
            endcase
         end
         isotp_rr_pkg::ST_RD: begin
            pl_rd_en = 1'b1;
            state_in = isotp_rr_pkg::ST_LOAD;
         end
         isotp_rr_pkg::ST_LOAD: begin
            if (!out_valid_ff || rsp_tready) begin
               out_load       = 1'b1;
               out_data_in    = {em_n, em_bytes, em_pos_ff[4:0], em_rec_ff.declared,
                                 em_rec_ff.ts, em_rec_ff.meta, em_rec_ff.key};
               out_partial_in = em_partial_ff;
               out_last_in    = em_remain <= isotp_rr_pkg::FILL_W'(8);
               if (em_remain <= isotp_rr_pkg::FILL_W'(8)) begin
                  state_in = isotp_rr_pkg::ST_POST;
               end else begin
                  em_pos_in = em_pos_ff + 1'b1;
                  state_in  = isotp_rr_pkg::ST_RD;
               end
            end
         end
         isotp_rr_pkg::ST_POST: begin
            case (ftype)
               isotp_rr_pkg::FT_SINGLE: state_in = isotp_rr_pkg::ST_SF;
               isotp_rr_pkg::FT_FIRST:  state_in = isotp_rr_pkg::ST_FFOPEN;
               default:                 state_in = isotp_rr_pkg::ST_IDLE;
            endcase
         end
         isotp_rr_pkg::ST_SF: begin
            if (flen == 4'd0 || flen > cap) begin
               state_in = isotp_rr_pkg::ST_IDLE;
            end else if (!out_valid_ff || rsp_tready) begin
               out_load       = 1'b1;
               out_data_in    = {flen, sf_bytes, 5'd0, 8'd0, flen, ts_ff, meta_ff, key};
               out_partial_in = 1'b0;
               out_last_in    = 1'b1;
               state_in       = isotp_rr_pkg::ST_IDLE;
            end
         end
         isotp_rr_pkg::ST_FFOPEN: begin
            state_in = isotp_rr_pkg::ST_IDLE;
            if (ff_decl <= isotp_rr_pkg::DECL_W'(MAX_MSG_BYTES) || MAX_MSG_BYTES >= 4096) begin
               if (!flags.full || (SLOTS == 1 && flags.hit)) begin
                  set_en               = 1'b1;
                  rec_wr_en            = 1'b1;
                  rec_wr_addr          = free_idx;
                  rec_wr_data.key      = key;
                  rec_wr_data.meta     = meta_ff;
                  rec_wr_data.ts       = ts_ff;
                  rec_wr_data.declared = ff_decl;
                  rec_wr_data.fill     = isotp_rr_pkg::FILL_W'(cap) - 1'b1;
                  pl_wr                = 1'b1;
                  pl_slot              = free_idx;
                  pl_fill              = '0;
                  pl_n                 = cap - 1'b1;
                  pl_src               = src_ff;
               end
            end
         end
         default: begin
            state_in = isotp_rr_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= isotp_rr_pkg::ST_IDLE;
         out_valid_ff <= 1'b0;
         ext_addr_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (out_load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
         if (csr_valid && csr_ready) begin
            ext_addr_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         id_ff   <= req_tdata[28:0];
         data_ff <= req_tdata[92:29];
         meta_ff <= {req_tdata[98], req_tdata[97], req_tdata[96:93]};
         ts_ff   <= req_tdata[162:99];
         ext_ff  <= ext_addr_ff;
      end
      em_rec_ff     <= em_rec_in;
      em_partial_ff <= em_partial_in;
      em_slot_ff    <= em_slot_in;
      em_pos_ff     <= em_pos_in;
      if (out_load) begin
         out_data_ff    <= out_data_in;
         out_partial_ff <= out_partial_in;
         out_last_ff    <= out_last_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_partial_ff;
   assign rsp_tlast  = out_last_ff;

   isotp_rr_keys #(
      .SLOTS(SLOTS)
   ) u_keys (
      .clock    (clock),
      .reset    (reset),
      .cmp_en   (cmp_en),
      .cmp_key  (key),
      .set_en   (set_en),
      .set_idx  (free_idx),
      .set_key  (key),
      .clr_en   (clr_en),
      .clr_idx  (clr_idx),
      .flags    (flags),
      .hit_idx  (hit_idx),
      .free_idx (free_idx)
   );

   isotp_rr_ram #(
      .WIDTH(REC_W),
      .DEPTH(SLOTS)
   ) u_rec_ram (
      .clock   (clock),
      .wr_en   (rec_wr_en),
      .wr_addr (rec_wr_addr),
      .wr_data (rec_wr_data),
      .rd_en   (rec_rd_en),
      .rd_addr (hit_idx),
      .rd_data (rec_rd_raw)
   );

   for (genvar g = 0; g < 8; g++) begin : g_lane
      isotp_rr_ram #(
         .WIDTH(8),
         .DEPTH(PDEPTH)
      ) u_lane_ram (
         .clock   (clock),
         .wr_en   (lane_we[g]),
         .wr_addr (lane_waddr[g]),
         .wr_data (lane_wdata[g]),
         .rd_en   (pl_rd_en),
         .rd_addr (pl_raddr),
         .rd_data (lane_rdata[g])
      );
   end

endmodule

// ===== design/isotp_rr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module isotp_rr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic                                    rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/isotp_rr_keys.sv =====
// Slot key registers, valid bits, key match and free-slot search.
module isotp_rr_keys #(
   parameter int SLOTS = isotp_rr_pkg::SLOTS_DEFAULT
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     cmp_en,
   input  logic [isotp_rr_pkg::KEY_W-1:0]           cmp_key,
   input  logic                                     set_en,
   input  logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] set_idx,
   input  logic [isotp_rr_pkg::KEY_W-1:0]           set_key,
   input  logic                                     clr_en,
   input  logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] clr_idx,
   output isotp_rr_pkg::slot_flags_type             flags,
   output logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] hit_idx,
   output logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] free_idx
);

   localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   logic [isotp_rr_pkg::KEY_W-1:0] key_ff [SLOTS];
   logic [SLOTS-1:0]               valid_ff;
   logic [SLOTS-1:0]               match_ff;
   logic [SLOTS-1:0]               match_in;

   always_comb begin
      for (int s = 0; s < SLOTS; s++) begin
         match_in[s] = valid_ff[s] && (key_ff[s] == cmp_key);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         match_ff <= '0;
      end else begin
         if (cmp_en) begin
            match_ff <= match_in;
         end
         if (set_en) begin
            valid_ff[set_idx] <= 1'b1;
         end
         if (clr_en) begin
            valid_ff[clr_idx] <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (set_en) begin
         key_ff[set_idx] <= set_key;
      end
   end

   // Lowest matching and lowest free slot win.
   always_comb begin
      hit_idx  = '0;
      free_idx = '0;
      for (int s = SLOTS - 1; s >= 0; s--) begin
         if (match_ff[s]) begin
            hit_idx = SW'(s);
         end
         if (!valid_ff[s]) begin
            free_idx = SW'(s);
         end
      end
      flags.hit  = |match_ff;
      flags.full = &valid_ff;
   end

endmodule

// ===== tb/tb_isotp_receive_reassembler.sv =====
// Self-checking testbench of the ISO-TP receive reassembler with a built-in message predictor.
`timescale 1ns / 100ps

module tb_isotp_receive_reassembler;

   localparam int NSLOT    = isotp_rr_pkg::SLOTS_DEFAULT;
   localparam int MAXBYTES = isotp_rr_pkg::MAX_MSG_BYTES_DEFAULT;
   localparam int WATCHDOG = 20000;

   // The last member sits in the lowest bits, so frame_id lands at bit 0.
   typedef struct packed {
      logic [63:0] stamp;
      logic        rcvd;
      logic        ext_id;
      logic [3:0]  bus;
      logic [63:0] frame_data;
      logic [28:0] frame_id;
   } frame_type;

   typedef struct packed {
      logic [36:0] msg_id;
      logic [3:0]  bus;
      logic        ext_id;
      logic        rcvd;
      logic [63:0] stamp;
      logic [11:0] declared;
      logic        partial;
      logic [4:0]  index;
      logic [63:0] data;
      logic [3:0]  nbytes;
      logic        last;
   } chunk_type;

   typedef struct {
      frame_type frm;
      logic      has_exp;
      chunk_type exp;
   } row_type;

   logic clock = 0, reset = 1;
   logic req_tvalid = 0, req_tready;
   logic [isotp_rr_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic rsp_tvalid, rsp_tready = 0;
   logic [isotp_rr_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic rsp_tuser, rsp_tlast;
   logic csr_valid = 0, csr_ready, csr_wdata = 0;

   isotp_receive_reassembler dut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   // Predictor state.
   logic        ea;
   logic        sv[NSLOT];
   logic [36:0] skey[NSLOT];
   logic [5:0]  smeta[NSLOT];
   logic [63:0] stime[NSLOT];
   logic [11:0] sdecl[NSLOT];
   int          sfill[NSLOT];
   logic [7:0]  spay[NSLOT][MAXBYTES];

   chunk_type expected_chunks[$];
   chunk_type last_pushed;
   int pushed = 0;
   int errors = 0, idle_cycles = 0, rsp_gap = 0;
   logic hold_rsp = 0, stim_done = 0;

   task automatic push_msg(input logic [36:0] key, input logic [5:0] meta,
                           input logic [63:0] ts, input logic [11:0] decl,
                           input logic part, input logic [7:0] b[MAXBYTES], input int cnt);
      int pos, n, idx;
      chunk_type c;
      pos = 0;
      idx = 0;
      while (pos < cnt) begin
         n = (cnt - pos > 8) ? 8 : cnt - pos;
         c = '0;
         c.msg_id = key; c.bus = meta[3:0]; c.ext_id = meta[4]; c.rcvd = meta[5];
         c.stamp = ts; c.declared = decl; c.partial = part; c.index = idx[4:0];
         for (int j = 0; j < n; j++) c.data[8*j +: 8] = b[pos+j];
         c.nbytes = n[3:0];
         c.last = (pos + n >= cnt);
         expected_chunks.push_back(c);
         last_pushed = c;
         pushed++;
         pos += n;
         idx++;
      end
   endtask

   function automatic int slot_of(input logic [36:0] key);
      for (int s = 0; s < NSLOT; s++) if (sv[s] && skey[s] == key) return s;
      return -1;
   endfunction

   task automatic release_slot(input int s, input logic part);
      push_msg(skey[s], smeta[s], stime[s], sdecl[s], part, spay[s], sfill[s]);
      sv[s] = 0;
   endtask

   task automatic predict_frame(input frame_type f);
      logic [7:0] b[8], buf8[MAXBYTES];
      logic [7:0] pci;
      logic [36:0] key;
      logic [5:0] meta;
      int base, s, ln, decl;
      for (int k = 0; k < 8; k++) b[k] = f.frame_data[8*k +: 8];
      pci = ea ? b[1] : b[0];
      base = ea ? 2 : 1;
      key = ea ? {f.frame_id, b[0]} : {8'd0, f.frame_id};
      meta = {f.rcvd, f.ext_id, f.bus};
      if (pci[7:4] == isotp_rr_pkg::FT_SINGLE || pci[7:4] == isotp_rr_pkg::FT_FIRST) begin
         s = slot_of(key);
         if (s >= 0) release_slot(s, sfill[s] < sdecl[s]);
      end
      if (pci[7:4] == isotp_rr_pkg::FT_SINGLE) begin
         if (pci[3:0] != 0 && pci[3:0] <= 8 - base) begin
            for (int j = 0; j < pci[3:0]; j++) buf8[j] = b[base+j];
            push_msg(key, meta, f.stamp, {8'd0, pci[3:0]}, 1'b0, buf8, pci[3:0]);
         end
      end else if (pci[7:4] == isotp_rr_pkg::FT_FIRST) begin
         decl = {pci[3:0], b[base]};
         s = -1;
         for (int k = NSLOT - 1; k >= 0; k--) if (!sv[k]) s = k;
         if (decl <= MAXBYTES && s >= 0) begin
            sv[s] = 1; skey[s] = key; smeta[s] = meta; stime[s] = f.stamp;
            sdecl[s] = decl[11:0];
            for (int j = 0; j < 7 - base; j++) spay[s][j] = b[base+1+j];
            sfill[s] = 7 - base;
         end
      end else if (pci[7:4] == isotp_rr_pkg::FT_CONSECUTIVE) begin
         s = slot_of(key);
         if (s >= 0) begin
            ln = (sdecl[s] > sfill[s]) ? sdecl[s] - sfill[s] : 0;
            if (ln > 8 - base) ln = 8 - base;
            for (int j = 0; j < ln; j++) spay[s][sfill[s]+j] = b[base+j];
            sfill[s] += ln;
            if (sfill[s] >= sdecl[s]) release_slot(s, 1'b0);
         end
      end
   endtask

   // Result side: short random stalls, a few long ones, plus one long hold-off.
   always @(negedge clock) begin
      if (reset || hold_rsp) rsp_tready <= 0;
      else if (rsp_gap > 0) begin
         rsp_tready <= 0;
         rsp_gap <= rsp_gap - 1;
      end
      else if ($urandom_range(0, 99) < 12) rsp_tready <= 0;
      else if ($urandom_range(0, 99) < 3) begin
         rsp_tready <= 0;
         rsp_gap <= $urandom_range(10, 40);
      end
      else rsp_tready <= 1;
   end

   always @(posedge clock) begin
      chunk_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '0;
         got.msg_id = rsp_tdata[36:0]; got.bus = rsp_tdata[40:37];
         got.ext_id = rsp_tdata[41]; got.rcvd = rsp_tdata[42];
         got.stamp = rsp_tdata[106:43]; got.declared = rsp_tdata[118:107];
         got.index = rsp_tdata[123:119]; got.data = rsp_tdata[187:124];
         got.nbytes = rsp_tdata[191:188]; got.partial = rsp_tuser; got.last = rsp_tlast;
         if (expected_chunks.size() == 0) begin
            $display("%0t unexpected word: expected none actual %h", $realtime, got);
            errors++;
         end else begin
            want = expected_chunks.pop_front();
            if (got != want) begin
               $display("%0t mismatch: expected %h actual %h", $realtime, want, got);
               errors++;
            end
         end
      end
   end

   // Watchdog on cycles without any accepted word.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset || stim_done)
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic send_frame(input frame_type f);
      req_tdata <= {5'd0, f};
      req_tvalid <= 1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_frame(f);
      @(negedge clock);
      if ($urandom_range(0, 3) == 0) begin
         req_tvalid <= 0;
         repeat ($urandom_range(0, 9) < 8 ? $urandom_range(1, 3) : $urandom_range(10, 40))
            @(negedge clock);
      end
   endtask

   task automatic write_mode(input logic v);
      csr_wdata <= v;
      csr_valid <= 1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      ea = v;
      @(negedge clock);
      csr_valid <= 0;
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (expected_chunks.size() != 0) @(negedge clock);
      repeat (30) @(negedge clock);
   endtask

   function automatic frame_type mk(input logic [28:0] id, input logic [63:0] d);
      frame_type f;
      f.frame_id = id; f.frame_data = d; f.bus = 4'($urandom); f.ext_id = 1'($urandom);
      f.rcvd = 1'($urandom); f.stamp = {$urandom, $urandom};
      return f;
   endfunction

   // Builds a random frame; mostly well-formed traffic on a few keys.
   function automatic frame_type rand_frame();
      logic [63:0] d;
      logic [7:0] pci;
      int r, ln;
      d = {$urandom, $urandom};
      r = $urandom_range(0, 99);
      if (r < 15) pci = {isotp_rr_pkg::FT_SINGLE, 4'($urandom_range(0, 15))};
      else if (r < 40) begin
         ln = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095) : $urandom_range(1, 40);
         pci = {isotp_rr_pkg::FT_FIRST, 4'(ln >> 8)};
         d[(ea ? 2 : 1)*8 +: 8] = ln[7:0];
      end else if (r < 92) pci = {isotp_rr_pkg::FT_CONSECUTIVE, 4'($urandom)};
      else pci = {4'($urandom_range(3, 15)), 4'($urandom)};
      d[(ea ? 1 : 0)*8 +: 8] = pci;
      if (ea) d[7:0] = $urandom_range(0, 2) == 0 ? 8'hFF : 8'($urandom_range(0, 2));
      return mk($urandom_range(0, 9) == 0 ? 29'($urandom) : 29'($urandom_range(0, 9)), d);
   endfunction

   row_type rows[$];

   initial begin
      row_type r;
      frame_type f;
      int n_prev;
      ea = 0;
      for (int s = 0; s < NSLOT; s++) sv[s] = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      // Directed table: single frames, short first frame, table full, too long, ignored.
      r.has_exp = 0;
      r.exp = '0;
      r.frm = mk(29'h1FFFFFFF, 64'hFFEEDDCCBBAA9907);
      r.has_exp = 1;
      r.exp.msg_id = {8'd0, r.frm.frame_id}; r.exp.bus = r.frm.bus;
      r.exp.ext_id = r.frm.ext_id; r.exp.rcvd = r.frm.rcvd; r.exp.stamp = r.frm.stamp;
      r.exp.declared = 12'd7; r.exp.data = 64'h00FFEEDDCCBBAA99;
      r.exp.nbytes = 4'd7; r.exp.last = 1'b1;
      rows.push_back(r);
      r.has_exp = 0;
      r.frm = mk(29'h0, 64'h0000000000000000); rows.push_back(r);
      r.frm = mk(29'h5, 64'hFFFFFFFFFFFFFF08); rows.push_back(r);
      r.frm = mk(29'h6, 64'h665544332211_0210); rows.push_back(r);
      r.frm = mk(29'h6, 64'h0000000000AA_BB21); rows.push_back(r);
      r.frm = mk(29'h7, 64'h665544332211_1410); rows.push_back(r);
      r.frm = mk(29'h7, 64'h07060504030201_21); rows.push_back(r);
      r.frm = mk(29'h7, 64'h0E0D0C0B0A0908_22); rows.push_back(r);
      r.frm = mk(29'h8, 64'h0000000000_0111); rows.push_back(r);
      r.frm = mk(29'h9, 64'h0000000000_FF1F); rows.push_back(r);
      r.frm = mk(29'h9, 64'h0000000000_0030); rows.push_back(r);
      r.frm = mk(29'h9, 64'h0000000000_00F0); rows.push_back(r);
      r.frm = mk(29'h9, 64'h0000000000_0021); rows.push_back(r);
      for (int k = 0; k < 9; k++) begin
         r.frm = mk(29'(16 + k), 64'h1122334455_6410); rows.push_back(r);
      end
      r.frm = mk(29'h10, 64'h0000000000_0301); rows.push_back(r);
      r.frm = mk(29'h11, 64'h0000000000_0300); rows.push_back(r);
      foreach (rows[i]) begin
         n_prev = pushed;
         send_frame(rows[i].frm);
         if (rows[i].has_exp && (pushed != n_prev + 1 || last_pushed != rows[i].exp)) begin
            $display("%0t row %0d: expected %h actual %h", $realtime, i, rows[i].exp,
                     last_pushed);
            errors++;
         end
      end
      // Flush everything still open.
      for (int k = 0; k < 30; k++) send_frame(mk(29'(k), 64'h0000000000000301));
      drain();

      // Long receiver hold-off with the sender still offering.
      hold_rsp = 1;
      fork
         begin
            repeat (300) @(negedge clock);
            hold_rsp = 0;
         end
         for (int k = 0; k < 20; k++) send_frame(mk(29'(k % 3), 64'h0102030405060707));
      join
      drain();

      for (int ph = 0; ph < 4; ph++) begin
         write_mode(ph[0] ? 1'b1 : 1'b0);
         for (int k = 0; k < 87; k++) send_frame(rand_frame());
         for (int k = 0; k < 10; k++) begin
            f = rand_frame();
            f.frame_data[(ea ? 1 : 0)*8 +: 8] = {isotp_rr_pkg::FT_SINGLE, 4'h0};
            send_frame(f);
         end
         drain();
      end
      // Wipe remaining open slots of both addressing modes.
      for (int s = 0; s < NSLOT; s++) if (sv[s]) begin
         f = mk(skey[s][36:8], {56'd0, skey[s][7:0]});
         if (ea) f.frame_data[15:8] = 8'h00;
         else begin f.frame_id = skey[s][28:0]; f.frame_data = 64'h0; end
         send_frame(f);
      end
      drain();
      stim_done = 1;
      if (errors == 0 && expected_chunks.size() == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

endmodule
